@@ design/yfdtd_pkg.sv @@
// Shared types and codes for the 2D Yee field solver.
package yfdtd_pkg;

    localparam int DW = 32;

    typedef logic signed [DW-1:0] t_word;

    localparam logic [2:0] OP_WR_E = 3'd0;
    localparam logic [2:0] OP_WR_B = 3'd1;
    localparam logic [2:0] OP_WR_J = 3'd2;
    localparam logic [2:0] OP_RD_E = 3'd3;
    localparam logic [2:0] OP_RD_B = 3'd4;
    localparam logic [2:0] OP_STEP = 3'd5;

    localparam logic [1:0] CFG_COURANT_X = 2'd0;
    localparam logic [1:0] CFG_COURANT_Y = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RD_K,
        S_RD_X,
        S_RD_Y,
        S_RD_W,
        S_MUL,
        S_ACC,
        S_WRITE
    } t_state;

    typedef enum logic [1:0] {
        PH_B1,
        PH_E,
        PH_B2
    } t_phase;

endpackage

@@ design/yee_fdtd_field_solver_2d.sv @@
// Periodic 2D Yee field solver: cell stores, sequencer and shared multiplier.
// Write or unknown command: result in the cycle after accept; cell read: via S_READ.
// A step runs three grid sweeps through one shared 33x33 multiplier:
//   per cell: three reads, four multiply-accumulate terms for a B sweep and seven
//   for the E sweep, then one write-back; one request at a time.
// After reset a clearing pass over all GRID_COLS * GRID_ROWS cells zeroes every store;
// no request is taken until it ends. Configuration writes are taken at any time.
module yee_fdtd_field_solver_2d
    import yfdtd_pkg::*;
#(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_cell_col,
    input  logic [5:0]  i_cell_row,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_read_x,
    output logic signed [31:0] o_read_y,
    output logic signed [31:0] o_read_z,
    output logic        o_saturated
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int ACW   = 50;
    localparam int SW    = 51;
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(GRID_COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(GRID_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_ROWS - 1);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * COLS_A + AW'(col);
    endfunction

    // configuration
    logic [16:0] r_cx, r_cy;
    logic [30:0] r_ts;

    // control
    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_clr, n_clr;
    logic [2:0]      r_idx, n_idx;
    logic [2:0]      r_op, n_op;
    logic            r_hv, n_hv;
    logic            r_satf, n_satf;
    logic            r_ov, n_ov;
    logic            r_sato, n_sato;
    t_word           r_rd [3];
    t_word           n_rd [3];

    // datapath
    t_word                  r_cs [3], n_cs [3];
    t_word                  r_xs [3], n_xs [3];
    t_word                  r_ys [3], n_ys [3];
    t_word                  r_ct [3], n_ct [3];
    t_word                  r_cj [3], n_cj [3];
    logic signed [65:0]     r_prod, n_prod;
    logic signed [ACW-1:0]  r_acc [3];
    logic signed [ACW-1:0]  n_acc [3];

    // memory ports
    logic            we_e, we_b, we_j;
    logic [AW-1:0]   wr_addr, rd_addr;
    t_word           wr_data [3];
    t_word           q_e [3], q_b [3], q_j [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_comp
            t_word m_e [CELLS];
            t_word m_b [CELLS];
            t_word m_j [CELLS];
            t_word r_qe, r_qb, r_qj;
            always_ff @(posedge i_clk) begin
                if (we_e) m_e[wr_addr] <= wr_data[g];
                if (we_b) m_b[wr_addr] <= wr_data[g];
                if (we_j) m_j[wr_addr] <= wr_data[g];
                r_qe <= m_e[rd_addr];
                r_qb <= m_b[rd_addr];
                r_qj <= m_j[rd_addr];
            end
            assign q_e[g] = r_qe;
            assign q_b[g] = r_qb;
            assign q_j[g] = r_qj;
        end
    endgenerate

    logic            in_acc, host_ok, is_e;
    logic [AW-1:0]   host_addr, k, kx, ky;
    logic [CW-1:0]   nb_col;
    logic [RW-1:0]   nb_row;
    logic [31:0]     coef;
    t_word           ctr, nb, jv;
    logic            use_j, neg, sat_any, last_idx;
    logic [1:0]      tgt;
    logic signed [32:0]     diff, opnd;
    logic signed [65:0]     shifted;
    logic signed [ACW-1:0]  term;
    logic signed [SW-1:0]   sum [3];
    t_word           sat_val [3];
    logic [2:0]      sat_bit;

    assign in_acc    = i_in_valid && o_in_ready;
    assign host_ok   = (int'(i_cell_col) < GRID_COLS) && (int'(i_cell_row) < GRID_ROWS);
    assign host_addr = AW'(i_cell_row) * COLS_A + AW'(i_cell_col);
    assign is_e      = (r_phase == PH_E);

    // neighbours: forward for B sweeps, backward for the E sweep, wrapping at the edges
    always_comb begin
        if (is_e) begin
            nb_col = (r_col == '0) ? LAST_COL : r_col - 1'b1;
            nb_row = (r_row == '0) ? LAST_ROW : r_row - 1'b1;
        end else begin
            nb_col = (r_col == LAST_COL) ? '0 : r_col + 1'b1;
            nb_row = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
        end
    end
    assign k  = cell_addr(r_row, r_col);
    assign kx = cell_addr(r_row, nb_col);
    assign ky = cell_addr(nb_row, r_col);

    // term selection for the shared multiplier
    always_comb begin
        coef  = '0;
        ctr   = '0;
        nb    = '0;
        jv    = '0;
        use_j = 1'b0;
        tgt   = 2'd0;
        unique case (r_idx)
            3'd0: begin coef = 32'(r_cy); ctr = r_cs[2]; nb = r_ys[2]; tgt = 2'd0; end
            3'd1: begin coef = 32'(r_cx); ctr = r_cs[2]; nb = r_xs[2]; tgt = 2'd1; end
            3'd2: begin coef = 32'(r_cx); ctr = r_cs[1]; nb = r_xs[1]; tgt = 2'd2; end
            3'd3: begin coef = 32'(r_cy); ctr = r_cs[0]; nb = r_ys[0]; tgt = 2'd2; end
            3'd4: begin coef = 32'(r_ts); jv = r_cj[0]; use_j = 1'b1; tgt = 2'd0; end
            3'd5: begin coef = 32'(r_ts); jv = r_cj[1]; use_j = 1'b1; tgt = 2'd1; end
            3'd6: begin coef = 32'(r_ts); jv = r_cj[2]; use_j = 1'b1; tgt = 2'd2; end
            default: begin coef = '0; end
        endcase
        diff = is_e ? (33'(ctr) - 33'(nb)) : (33'(nb) - 33'(ctr));
        opnd = use_j ? 33'(jv) : diff;
        neg  = use_j ? 1'b1 : (r_idx[0] == is_e);
    end

    assign shifted  = is_e ? (r_prod >>> 16) : (r_prod >>> 17);
    assign term     = shifted[ACW-1:0];
    assign last_idx = is_e ? (r_idx == 3'd6) : (r_idx == 3'd3);

    // add to the old value and saturate once
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = SW'(r_ct[c]) + SW'(r_acc[c]);
            if (sum[c] > SAT_MAX) begin
                sat_val[c] = 32'sh7FFFFFFF;
                sat_bit[c] = 1'b1;
            end else if (sum[c] < SAT_MIN) begin
                sat_val[c] = 32'sh80000000;
                sat_bit[c] = 1'b1;
            end else begin
                sat_val[c] = sum[c][31:0];
                sat_bit[c] = 1'b0;
            end
        end
        sat_any = |sat_bit;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_clr   = r_clr;
        n_idx   = r_idx;
        n_op    = r_op;
        n_hv    = r_hv;
        n_satf  = r_satf;
        n_ov    = r_ov;
        n_sato  = r_sato;
        n_prod  = r_prod;
        for (int c = 0; c < 3; c++) begin
            n_rd[c]  = r_rd[c];
            n_cs[c]  = r_cs[c];
            n_xs[c]  = r_xs[c];
            n_ys[c]  = r_ys[c];
            n_ct[c]  = r_ct[c];
            n_cj[c]  = r_cj[c];
            n_acc[c] = r_acc[c];
        end
        we_e       = 1'b0;
        we_b       = 1'b0;
        we_j       = 1'b0;
        wr_addr    = host_addr;
        rd_addr    = host_addr;
        wr_data[0] = i_value_x;
        wr_data[1] = i_value_y;
        wr_data[2] = i_value_z;
        o_in_ready = 1'b0;

        // drain the output register first; a new result may refill it below
        if (r_ov && i_out_ready) n_ov = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                we_e    = 1'b1;
                we_b    = 1'b1;
                we_j    = 1'b1;
                wr_addr = r_clr;
                for (int c = 0; c < 3; c++) wr_data[c] = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_CELL) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !r_ov || i_out_ready;
                if (in_acc) begin
                    n_op   = i_opcode;
                    n_hv   = host_ok;
                    n_sato = 1'b0;
                    for (int c = 0; c < 3; c++) n_rd[c] = '0;
                    unique case (i_opcode)
                        OP_WR_E: begin we_e = host_ok; n_ov = 1'b1; end
                        OP_WR_B: begin we_b = host_ok; n_ov = 1'b1; end
                        OP_WR_J: begin we_j = host_ok; n_ov = 1'b1; end
                        OP_RD_E, OP_RD_B: n_state = S_READ;
                        OP_STEP: begin
                            n_satf  = 1'b0;
                            n_phase = PH_B1;
                            n_col   = '0;
                            n_row   = '0;
                            n_state = S_RD_K;
                        end
                        default: n_ov = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_ov = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    if (!r_hv) n_rd[c] = '0;
                    else       n_rd[c] = (r_op == OP_RD_E) ? q_e[c] : q_b[c];
                end
                n_state = S_IDLE;
            end
            S_RD_K: begin
                rd_addr = k;
                n_idx   = '0;
                for (int c = 0; c < 3; c++) n_acc[c] = '0;
                n_state = S_RD_X;
            end
            S_RD_X: begin
                rd_addr = kx;
                for (int c = 0; c < 3; c++) begin
                    n_cs[c] = is_e ? q_b[c] : q_e[c];
                    n_ct[c] = is_e ? q_e[c] : q_b[c];
                    n_cj[c] = q_j[c];
                end
                n_state = S_RD_Y;
            end
            S_RD_Y: begin
                rd_addr = ky;
                for (int c = 0; c < 3; c++) n_xs[c] = is_e ? q_b[c] : q_e[c];
                n_state = S_RD_W;
            end
            S_RD_W: begin
                for (int c = 0; c < 3; c++) n_ys[c] = is_e ? q_b[c] : q_e[c];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = $signed({1'b0, coef}) * opnd;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc[tgt] = neg ? (r_acc[tgt] - term) : (r_acc[tgt] + term);
                if (last_idx) begin
                    n_state = S_WRITE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_WRITE: begin
                wr_addr = k;
                we_e    = is_e;
                we_b    = !is_e;
                for (int c = 0; c < 3; c++) wr_data[c] = sat_val[c];
                if (sat_any) n_satf = 1'b1;
                n_state = S_RD_K;
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_row = '0;
                        unique case (r_phase)
                            PH_B1: n_phase = PH_E;
                            PH_E:  n_phase = PH_B2;
                            PH_B2: begin
                                n_ov    = 1'b1;
                                n_sato  = r_satf || sat_any;
                                n_state = S_IDLE;
                            end
                            default: n_phase = PH_B1;
                        endcase
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_B1;
            r_col   <= '0;
            r_row   <= '0;
            r_clr   <= '0;
            r_idx   <= '0;
            r_satf  <= 1'b0;
            r_ov    <= 1'b0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_ts    <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_satf  <= n_satf;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COURANT_X: r_cx <= i_cfg_data[16:0];
                    CFG_COURANT_Y: r_cy <= i_cfg_data[16:0];
                    CFG_TIME_STEP: r_ts <= i_cfg_data;
                    default: r_ts <= r_ts;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_hv   <= n_hv;
        r_sato <= n_sato;
        r_prod <= n_prod;
        for (int c = 0; c < 3; c++) begin
            r_rd[c]  <= n_rd[c];
            r_cs[c]  <= n_cs[c];
            r_xs[c]  <= n_xs[c];
            r_ys[c]  <= n_ys[c];
            r_ct[c]  <= n_ct[c];
            r_cj[c]  <= n_cj[c];
            r_acc[c] <= n_acc[c];
        end
    end

    assign o_out_valid = r_ov;
    assign o_read_x    = r_rd[0];
    assign o_read_y    = r_rd[1];
    assign o_read_z    = r_rd[2];
    assign o_saturated = r_sato;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the 2D Yee field solver: cell access and step requests.
`timescale 1ns / 1ps

module tb_top
    import yfdtd_pkg::*;
();

    localparam int COLS        = 64;
    localparam int ROWS        = 64;
    localparam int CELLS       = COLS * ROWS;
    localparam int CALM_TAIL   = 60;
    localparam int CYCLE_LIMIT = 5000000;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] OP_BAD_A  = 3'd6;
    localparam logic [2:0] OP_BAD_B  = 3'd7;
    localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] W_MIN = 32'sh80000000;

    typedef struct {
        logic [2:0]         op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_cell_req;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic               sat;
    } t_cell_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode = '0;
    logic [5:0]  i_cell_col = '0;
    logic [5:0]  i_cell_row = '0;
    logic signed [31:0] i_value_x = '0;
    logic signed [31:0] i_value_y = '0;
    logic signed [31:0] i_value_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [31:0] o_read_x;
    logic signed [31:0] o_read_y;
    logic signed [31:0] o_read_z;
    logic        o_saturated;

    yee_fdtd_field_solver_2d #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [31:0] e_x [CELLS], e_y [CELLS], e_z [CELLS];
    logic signed [31:0] b_x [CELLS], b_y [CELLS], b_z [CELLS];
    logic signed [31:0] j_x [CELLS], j_y [CELLS], j_z [CELLS];
    longint coef_x = 0, coef_y = 0, coef_dt = 0;
    bit     step_sat;

    t_cell_req  pending_reqs [$];
    t_cell_resp expected_resps [$];
    int mismatches = 0;
    int resps_seen = 0;

    function automatic longint scaled(longint c, longint d, int sh);
        return (c * d) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] old, longint inc);
        longint s;
        s = longint'(old) + inc;
        if (s > 64'sd2147483647) begin
            step_sat = 1'b1;
            return W_MAX;
        end
        if (s < -64'sd2147483648) begin
            step_sat = 1'b1;
            return W_MIN;
        end
        return s[31:0];
    endfunction

    function automatic void sweep_bfield();
        int k, kx, ky;
        longint dzy, dzx, dyx, dxy;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                k   = r * COLS + c;
                kx  = r * COLS + ((c + 1) % COLS);
                ky  = ((r + 1) % ROWS) * COLS + c;
                dzy = longint'(e_z[ky]) - e_z[k];
                dzx = longint'(e_z[kx]) - e_z[k];
                dyx = longint'(e_y[kx]) - e_y[k];
                dxy = longint'(e_x[ky]) - e_x[k];
                b_x[k] = clamp_add(b_x[k], -scaled(coef_y, dzy, 17));
                b_y[k] = clamp_add(b_y[k], scaled(coef_x, dzx, 17));
                b_z[k] = clamp_add(b_z[k],
                    -scaled(coef_x, dyx, 17) + scaled(coef_y, dxy, 17));
            end
        end
    endfunction

    function automatic void sweep_efield();
        int k, kx, ky;
        longint dzy, dzx, dyx, dxy;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                k   = r * COLS + c;
                kx  = r * COLS + ((c + COLS - 1) % COLS);
                ky  = ((r + ROWS - 1) % ROWS) * COLS + c;
                dzy = longint'(b_z[k]) - b_z[ky];
                dzx = longint'(b_z[k]) - b_z[kx];
                dyx = longint'(b_y[k]) - b_y[kx];
                dxy = longint'(b_x[k]) - b_x[ky];
                e_x[k] = clamp_add(e_x[k],
                    scaled(coef_y, dzy, 16) - scaled(coef_dt, j_x[k], 16));
                e_y[k] = clamp_add(e_y[k],
                    -scaled(coef_x, dzx, 16) - scaled(coef_dt, j_y[k], 16));
                e_z[k] = clamp_add(e_z[k],
                    scaled(coef_x, dyx, 16) - scaled(coef_y, dxy, 16)
                    - scaled(coef_dt, j_z[k], 16));
            end
        end
    endfunction

    function automatic void solver_apply(t_cell_req q);
        t_cell_resp p;
        int k;
        k = q.row * COLS + q.col;
        p = '{rx: '0, ry: '0, rz: '0, sat: 1'b0};
        case (q.op)
            OP_WR_E: begin
                e_x[k] = q.vx; e_y[k] = q.vy; e_z[k] = q.vz;
            end
            OP_WR_B: begin
                b_x[k] = q.vx; b_y[k] = q.vy; b_z[k] = q.vz;
            end
            OP_WR_J: begin
                j_x[k] = q.vx; j_y[k] = q.vy; j_z[k] = q.vz;
            end
            OP_RD_E: begin
                p.rx = e_x[k]; p.ry = e_y[k]; p.rz = e_z[k];
            end
            OP_RD_B: begin
                p.rx = b_x[k]; p.ry = b_y[k]; p.rz = b_z[k];
            end
            OP_STEP: begin
                step_sat = 1'b0;
                sweep_bfield();
                sweep_efield();
                sweep_bfield();
                p.sat = step_sat;
            end
            default: ;
        endcase
        expected_resps.push_back(p);
    endfunction

    // Request driver
    t_cell_req cur_req;
    int  gap_left = 0;
    bit  in_busy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            in_busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                solver_apply(cur_req);
                in_busy = 1'b0;
            end
            if (!in_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_opcode   <= cur_req.op;
                    i_cell_col <= cur_req.col;
                    i_cell_row <= cur_req.row;
                    i_value_x  <= cur_req.vx;
                    i_value_y  <= cur_req.vy;
                    i_value_z  <= cur_req.vz;
                    i_in_valid <= 1'b1;
                    if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 18);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    int  stall_left = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    t_cell_resp want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                resps_seen++;
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%h y=%h z=%h sat=%b",
                                 o_read_x, o_read_y, o_read_z, o_saturated);
                end else begin
                    want = expected_resps.pop_front();
                    if (o_read_x !== want.rx || o_read_y !== want.ry ||
                        o_read_z !== want.rz || o_saturated !== want.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%h y=%h z=%h sat=%b, ",
                                      "got x=%h y=%h z=%h sat=%b"},
                                     want.rx, want.ry, want.rz, want.sat,
                                     o_read_x, o_read_y, o_read_z, o_saturated);
                    end
                end
                // long hold-off so the block backs up into its input
                if (resps_seen == 100 && !held_once) begin
                    held_once = 1'b1;
                    hold_left = 400;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_COURANT_X: coef_x  = longint'(val & 31'h1ffff);
            CFG_COURANT_Y: coef_y  = longint'(val & 31'h1ffff);
            CFG_TIME_STEP: coef_dt = longint'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic add_req(logic [2:0] op, int col, int row,
                           logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz);
        t_cell_req q;
        q = '{op: op, col: 6'(col), row: 6'(row), vx: vx, vy: vy, vz: vz};
        pending_reqs.push_back(q);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return W_MAX;
            1: return W_MIN;
            2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(int count, int step_at);
        logic [2:0] op;
        int col, row;
        for (int n = 0; n < count; n++) begin
            if (n == step_at) begin
                op = OP_STEP;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:     op = OP_WR_E;
                    4, 5, 6:        op = OP_WR_B;
                    7, 8:           op = OP_WR_J;
                    9, 10, 11, 12:  op = OP_RD_E;
                    13, 14, 15, 16: op = OP_RD_B;
                    17:             op = OP_BAD_A;
                    18:             op = OP_BAD_B;
                    default:        op = OP_RD_E;
                endcase
            end
            // keep half the traffic near the wrap corner so reads find written cells
            if ($urandom_range(0, 1)) begin
                col = ($urandom_range(0, 3) + COLS - 2) % COLS;
                row = ($urandom_range(0, 3) + ROWS - 2) % ROWS;
            end else begin
                col = $urandom_range(0, COLS - 1);
                row = $urandom_range(0, ROWS - 1);
            end
            add_req(op, col, row, pick_word(), pick_word(), pick_word());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_COURANT_X, 31'd65536);
        write_reg(CFG_COURANT_Y, 31'd65536);
        write_reg(CFG_TIME_STEP, 31'h7fffffff);

        add_req(OP_WR_E, 0, 0, W_MAX, W_MIN, W_MAX);
        add_req(OP_WR_E, 63, 63, W_MIN, W_MAX, W_MIN);
        add_req(OP_WR_B, 0, 63, 32'sd1, -32'sd1, 32'sh10000);
        add_req(OP_WR_J, 63, 63, W_MIN, W_MAX, 32'sh7fff);
        add_req(OP_WR_J, 5, 7, 32'sh10000, -32'sh18000, 32'sd3);
        add_req(OP_RD_E, 0, 0, '0, '0, '0);
        add_req(OP_RD_E, 63, 63, '0, '0, '0);
        add_req(OP_RD_B, 0, 63, '0, '0, '0);
        add_req(OP_RD_B, 63, 63, '0, '0, '0);
        add_req(OP_BAD_A, 63, 63, W_MAX, W_MIN, -32'sd1);
        add_req(OP_BAD_B, 0, 0, -32'sd1, W_MAX, W_MIN);
        add_req(OP_STEP, 0, 0, '0, '0, '0);
        add_req(OP_RD_E, 0, 0, '0, '0, '0);
        add_req(OP_RD_E, 63, 0, '0, '0, '0);
        add_req(OP_RD_E, 0, 63, '0, '0, '0);
        add_req(OP_RD_E, 63, 63, '0, '0, '0);
        add_req(OP_RD_E, 5, 7, '0, '0, '0);
        add_req(OP_RD_B, 0, 0, '0, '0, '0);
        add_req(OP_RD_B, 1, 0, '0, '0, '0);
        add_req(OP_RD_B, 0, 1, '0, '0, '0);
        add_req(OP_RD_B, 63, 63, '0, '0, '0);
        add_req(OP_RD_B, 62, 63, '0, '0, '0);
        drain();

        // out-of-width bits are dropped; the spare index is ignored
        write_reg(CFG_COURANT_X, 31'h7fffffff);
        write_reg(CFG_COURANT_Y, 31'd0);
        write_reg(CFG_TIME_STEP, 31'd0);
        write_reg(CFG_SPARE, 31'h5a5a5a5a);
        add_random(250, 120);
        drain();

        write_reg(CFG_COURANT_X, 31'($urandom_range(0, 65536)));
        write_reg(CFG_COURANT_Y, 31'($urandom_range(0, 65536)));
        write_reg(CFG_TIME_STEP, 31'($urandom_range(0, 32'h30000)));
        add_random(280, 140);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
design/yfdtd_pkg.sv
design/yee_fdtd_field_solver_2d.sv
tb/tb_top.sv
